// File: design/afc_pkg.sv
`timescale 1ns / 1ps
package afc_pkg;

  localparam int FRAC_BITS    = 16;
  // angle in Q17.30 before reduction, magnitude only
  localparam int ZW           = 63 - FRAC_BITS;
  // reduction by 2*pi: reciprocal estimate, multiply back, one correction
  localparam int MOD_STEPS    = 3;
  localparam int MOD_CW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int ZH_SHIFT     = ZW - 31;
  localparam int REC_FRAC     = 34;
  localparam int REC_SHIFT    = ZH_SHIFT + REC_FRAC;
  localparam int QW           = 29 - FRAC_BITS;
  // cordic working width, Q2.30 with headroom
  localparam int CW           = 36;
  localparam int CORDIC_STEPS = 30;
  // tangent dividend width and its step counter
  localparam int DIVW         = 32 + FRAC_BITS;
  localparam int DIV_CW       = $clog2(DIVW);
  // accumulator of the compose engine
  localparam int AW           = 67 - FRAC_BITS;
  localparam int SATW         = 64;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE = 32'sd1 <<< FRAC_BITS;
  localparam q_t Q_MAX = 32'sh7FFFFFFF;
  localparam q_t Q_MIN = 32'sh80000000;

  localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [CW-1:0] Q30_GAIN    = 36'sd652032874;
  localparam logic [ZW-1:0]        TWO_PI_MAG  = ZW'(64'd6746518852);
  // floor(2^REC_SHIFT / 2*pi in Q2.30), never above the true reciprocal
  localparam logic [31:0]          TWO_PI_REC  =
    32'((64'd1 << REC_SHIFT) / 64'd6746518852);

  localparam logic signed [SATW-1:0] SAT_HI = 64'sh000000007FFFFFFF;
  localparam logic signed [SATW-1:0] SAT_LO = 64'shFFFFFFFF80000000;

  typedef enum logic [2:0] {
    OP_TRANSLATE = 3'd0,
    OP_SCALE     = 3'd1,
    OP_ROTATE    = 3'd2,
    OP_SKEW_X    = 3'd3,
    OP_SKEW_Y    = 3'd4,
    OP_MATRIX    = 3'd5
  } op_kind_t;

  typedef enum logic [2:0] {
    FR_IDLE, FR_MOD, FR_FOLD, FR_CORDIC, FR_TRIG, FR_DIV, FR_TAN, FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_ACC, BK_COPY, BK_ADD, BK_EMIT
  } back_state_t;

  // one operation matrix handed from front to back
  typedef struct packed {
    q_t [5:0] m;
    q_t       ox;
    q_t       oy;
    logic     last;
  } op_word_t;

  function automatic q_t sat32(input logic signed [SATW-1:0] v);
    if (v > SAT_HI) begin
      return Q_MAX;
    end else if (v < SAT_LO) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] one;
    one = 36'sd1;
    case (i)
      5'd0:    return 36'sd843314857;
      5'd1:    return 36'sd497837829;
      5'd2:    return 36'sd263043837;
      5'd3:    return 36'sd133525159;
      5'd4:    return 36'sd67021687;
      5'd5:    return 36'sd33543516;
      5'd6:    return 36'sd16775851;
      5'd7:    return 36'sd8388437;
      5'd8:    return 36'sd4194283;
      5'd9:    return 36'sd2097149;
      5'd10:   return 36'sd1048576;
      5'd11:   return 36'sd524288;
      default: return one <<< (5'd30 - i);
    endcase
  endfunction

endpackage

// File: design/afc_if.sv
`timescale 1ns / 1ps
interface afc_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op_kind;
  logic signed [31:0] param_a;
  logic signed [31:0] param_b;
  logic signed [31:0] param_c;
  logic signed [31:0] param_d;
  logic signed [31:0] param_e;
  logic signed [31:0] param_f;
  logic signed [31:0] pivot_x;
  logic signed [31:0] pivot_y;
  logic              last_op;
  modport source (output valid, op_kind, param_a, param_b, param_c, param_d, param_e,
                  param_f, pivot_x, pivot_y, last_op, input ready);
  modport sink (input valid, op_kind, param_a, param_b, param_c, param_d, param_e,
                param_f, pivot_x, pivot_y, last_op, output ready);
endinterface

interface afc_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_m11;
  logic signed [31:0] out_m12;
  logic signed [31:0] out_m21;
  logic signed [31:0] out_m22;
  logic signed [31:0] out_dx;
  logic signed [31:0] out_dy;
  modport source (output valid, out_m11, out_m12, out_m21, out_m22, out_dx, out_dy,
                  input ready);
  modport sink (input valid, out_m11, out_m12, out_m21, out_m22, out_dx, out_dy,
                output ready);
endinterface

// File: design/afc_front.sv
`timescale 1ns / 1ps
module afc_front
  import afc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  afc_in_if.sink   in_ch,
  output logic     word_valid,
  input  logic     word_ready,
  output op_word_t word
);

  localparam logic [4:0]        CORDIC_LAST = 5'(CORDIC_STEPS - 1);
  localparam logic [MOD_CW-1:0] MOD_FIRST   = MOD_CW'(MOD_STEPS - 1);
  localparam logic [MOD_CW-1:0] MOD_MULB    = MOD_CW'(1);
  localparam logic [DIV_CW-1:0] DIV_FIRST   = DIV_CW'(DIVW - 1);

  front_state_t state, state_next;

  logic [2:0]           kind;
  logic                 last;
  q_t                   ox, oy;
  q_t                   m [6];
  logic                 z_neg;
  logic [ZW-1:0]        zmag;
  logic [MOD_CW-1:0]    kcnt;
  logic [QW-1:0]        qe;
  logic signed [CW-1:0] z, x, y;
  logic                 fold_neg;
  logic [4:0]           icnt;
  logic [DIVW-1:0]      qn;
  logic [32:0]          rem;
  logic [31:0]          den;
  logic                 q_neg;
  logic [DIV_CW-1:0]    dcnt;

  logic [31:0]          a_mag;
  logic [62:0]          rec_prod;
  logic signed [CW-1:0] zr, zw, zf;
  logic                 zf_neg;
  logic signed [CW-1:0] cdx, cdy, cang;
  logic signed [CW-1:0] sin_v, cos_v, sin_sh, cos_sh;
  logic [CW-1:0]        sin_mag, cos_mag;
  logic [32:0]          rem_sh;
  q_t                   tan_v;

  always_comb begin
    a_mag    = in_ch.param_a[31] ? 32'(-in_ch.param_a) : 32'(in_ch.param_a);
    // quotient estimate never above the true one and at most one below
    rec_prod = 63'(zmag >> ZH_SHIFT) * 63'(TWO_PI_REC);

    // truncated remainder, then into [-pi, pi], then folded into [-pi/2, pi/2]
    zr = CW'(zmag);
    if (z_neg) begin
      zr = -zr;
    end
    if (zr > Q30_PI) begin
      zw = zr - Q30_TWO_PI;
    end else if (zr < -Q30_PI) begin
      zw = zr + Q30_TWO_PI;
    end else begin
      zw = zr;
    end
    zf_neg = 1'b0;
    if (zw > Q30_HALF_PI) begin
      zf     = zw - Q30_PI;
      zf_neg = 1'b1;
    end else if (zw < -Q30_HALF_PI) begin
      zf     = zw + Q30_PI;
      zf_neg = 1'b1;
    end else begin
      zf = zw;
    end

    cdx  = y >>> icnt;
    cdy  = x >>> icnt;
    cang = atan_q30(icnt);

    sin_v   = fold_neg ? -y : y;
    cos_v   = fold_neg ? -x : x;
    sin_sh  = sin_v >>> (30 - FRAC_BITS);
    cos_sh  = cos_v >>> (30 - FRAC_BITS);
    sin_mag = sin_v[CW-1] ? CW'(-sin_v) : CW'(sin_v);
    cos_mag = cos_v[CW-1] ? CW'(-cos_v) : CW'(cos_v);

    rem_sh = {rem[31:0], qn[DIVW-1]};
    tan_v  = q_neg ? sat32(-$signed(SATW'(qn))) : sat32($signed(SATW'(qn)));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op_kind == OP_ROTATE || in_ch.op_kind == OP_SKEW_X ||
              in_ch.op_kind == OP_SKEW_Y) begin
            state_next = FR_MOD;
          end else begin
            state_next = FR_PUSH;
          end
        end
      end
      FR_MOD:    if (kcnt == '0) state_next = FR_FOLD;
      FR_FOLD:   state_next = FR_CORDIC;
      FR_CORDIC: if (icnt == CORDIC_LAST) state_next = FR_TRIG;
      FR_TRIG: begin
        if (kind == OP_ROTATE || cos_v == '0) begin
          state_next = FR_PUSH;
        end else begin
          state_next = FR_DIV;
        end
      end
      FR_DIV:    if (dcnt == '0) state_next = FR_TAN;
      FR_TAN:    state_next = FR_PUSH;
      FR_PUSH:   if (word_ready) state_next = FR_IDLE;
      default:   state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == FR_IDLE);
    word_valid  = (state == FR_PUSH);
    word.ox     = ox;
    word.oy     = oy;
    word.last   = last;
    for (int i = 0; i < 6; i++) begin
      word.m[i] = m[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: begin
        kind  <= in_ch.op_kind;
        last  <= in_ch.last_op;
        ox    <= in_ch.pivot_x;
        oy    <= in_ch.pivot_y;
        z_neg <= in_ch.param_a[31];
        zmag  <= ZW'(a_mag) << (30 - FRAC_BITS);
        kcnt  <= MOD_FIRST;
        case (in_ch.op_kind)
          OP_TRANSLATE: begin
            m[0] <= Q_ONE;
            m[1] <= '0;
            m[2] <= '0;
            m[3] <= Q_ONE;
            m[4] <= in_ch.param_a;
            m[5] <= in_ch.param_b;
          end
          OP_SCALE: begin
            m[0] <= in_ch.param_a;
            m[1] <= '0;
            m[2] <= '0;
            m[3] <= in_ch.param_b;
            m[4] <= '0;
            m[5] <= '0;
          end
          OP_MATRIX: begin
            m[0] <= in_ch.param_a;
            m[1] <= in_ch.param_b;
            m[2] <= in_ch.param_c;
            m[3] <= in_ch.param_d;
            m[4] <= in_ch.param_e;
            m[5] <= in_ch.param_f;
          end
          default: begin
            m[0] <= Q_ONE;
            m[1] <= '0;
            m[2] <= '0;
            m[3] <= Q_ONE;
            m[4] <= '0;
            m[5] <= '0;
          end
        endcase
      end
      FR_MOD: begin
        // estimate the quotient, take it off, then one conditional subtract
        if (kcnt == MOD_FIRST) begin
          qe <= QW'(rec_prod >> REC_FRAC);
        end else if (kcnt == MOD_MULB) begin
          zmag <= zmag - ZW'(qe) * TWO_PI_MAG;
        end else if (zmag >= TWO_PI_MAG) begin
          zmag <= zmag - TWO_PI_MAG;
        end
        kcnt <= kcnt - 1'b1;
      end
      FR_FOLD: begin
        z        <= zf;
        fold_neg <= zf_neg;
        x        <= Q30_GAIN;
        y        <= '0;
        icnt     <= '0;
      end
      FR_CORDIC: begin
        if (!z[CW-1]) begin
          x <= x - cdx;
          y <= y + cdy;
          z <= z - cang;
        end else begin
          x <= x + cdx;
          y <= y - cdy;
          z <= z + cang;
        end
        icnt <= icnt + 1'b1;
      end
      FR_TRIG: begin
        qn    <= DIVW'(sin_mag) << FRAC_BITS;
        rem   <= '0;
        den   <= cos_mag[31:0];
        q_neg <= sin_v[CW-1] ^ cos_v[CW-1];
        dcnt  <= DIV_FIRST;
        if (kind == OP_ROTATE) begin
          m[0] <= sat32(SATW'(cos_sh));
          m[1] <= sat32(SATW'(sin_sh));
          m[2] <= sat32(-SATW'(sin_sh));
          m[3] <= sat32(SATW'(cos_sh));
        end else if (cos_v == '0) begin
          // vertical tangent saturates by the sign of the sine
          if (kind == OP_SKEW_X) begin
            m[2] <= sin_v[CW-1] ? Q_MIN : Q_MAX;
          end else begin
            m[1] <= sin_v[CW-1] ? Q_MIN : Q_MAX;
          end
        end
      end
      FR_DIV: begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          qn  <= {qn[DIVW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          qn  <= {qn[DIVW-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
      end
      FR_TAN: begin
        if (kind == OP_SKEW_X) begin
          m[2] <= tan_v;
        end else begin
          m[1] <= tan_v;
        end
      end
      FR_PUSH: ;
      default: ;
    endcase
  end

endmodule

// File: design/afc_fifo.sv
`timescale 1ns / 1ps
module afc_fifo
  import afc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  op_word_t wr_word,
  output logic     rd_valid,
  input  logic     rd_ready,
  output op_word_t rd_word
);

  op_word_t   slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  always_comb begin
    wr_ready = (count != 2'd2);
    rd_valid = (count != 2'd0);
    rd_word  = slot[rd_ptr];
    push     = wr_valid && wr_ready;
    pop      = rd_valid && rd_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= wr_word;
  end

endmodule

// File: design/afc_back.sv
`timescale 1ns / 1ps
module afc_back
  import afc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      word_valid,
  output logic      word_ready,
  input  op_word_t  word,
  afc_out_if.source out_ch
);

  localparam logic [3:0] STEP_COMPOSE_LAST = 4'd11;
  localparam logic [3:0] STEP_WRAP_LAST    = 4'd3;

  back_state_t state, state_next;

  q_t                   r_mat [6];
  q_t                   t_mat [6];
  q_t                   m_mat [6];
  q_t                   ox, oy;
  logic                 last;
  logic                 wrap;
  logic [3:0]           step;
  logic signed [AW-1:0] acc;
  logic signed [64:0]   prod;
  q_t                   wsat [2];
  q_t                   res_dx, res_dy;
  logic                 out_valid;

  logic                 term, col;
  logic [1:0]           row;
  logic signed [32:0]   opa;
  q_t                   opb, bias;
  logic signed [AW-1:0] acc_sum, acc_tot;
  q_t                   ent_sat;
  logic                 entry_done, emit_fire;

  always_comb begin
    term = step[0];
    col  = step[1];
    row  = step[3:2];
    if (!wrap) begin
      opa  = 33'(r_mat[{row, term}]);
      opb  = m_mat[{1'b0, term, col}];
      bias = (row == 2'd2) ? m_mat[{2'b10, col}] : '0;
    end else begin
      opa  = term ? -33'(oy) : -33'(ox);
      opb  = r_mat[{1'b0, term, col}];
      bias = r_mat[{2'b10, col}];
    end
    acc_sum    = acc + AW'(prod >>> FRAC_BITS);
    acc_tot    = acc_sum + AW'(bias);
    ent_sat    = sat32(SATW'(acc_tot));
    entry_done = wrap ? (step == STEP_WRAP_LAST) : (step == STEP_COMPOSE_LAST);
    emit_fire  = !out_valid || out_ch.ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (word_valid) state_next = BK_MUL;
      BK_MUL:  state_next = BK_ACC;
      BK_ACC: begin
        if (!term || !entry_done) begin
          state_next = BK_MUL;
        end else if (wrap) begin
          state_next = BK_ADD;
        end else begin
          state_next = BK_COPY;
        end
      end
      BK_COPY: state_next = last ? BK_MUL : BK_IDLE;
      BK_ADD:  state_next = BK_EMIT;
      BK_EMIT: if (emit_fire) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    word_ready   = (state == BK_IDLE);
    out_ch.valid = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wrap      <= 1'b0;
      r_mat[0]  <= Q_ONE;
      r_mat[1]  <= '0;
      r_mat[2]  <= '0;
      r_mat[3]  <= Q_ONE;
      r_mat[4]  <= '0;
      r_mat[5]  <= '0;
    end else begin
      if (state == BK_EMIT && emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          wrap <= 1'b0;
        end
        BK_COPY: begin
          for (int i = 0; i < 6; i++) begin
            r_mat[i] <= t_mat[i];
          end
          wrap <= last;
        end
        BK_EMIT: begin
          if (emit_fire) begin
            wrap      <= 1'b0;
            r_mat[0]  <= Q_ONE;
            r_mat[1]  <= '0;
            r_mat[2]  <= '0;
            r_mat[3]  <= Q_ONE;
            r_mat[4]  <= '0;
            r_mat[5]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        for (int i = 0; i < 6; i++) begin
          m_mat[i] <= word.m[i];
        end
        ox   <= word.ox;
        oy   <= word.oy;
        last <= word.last;
        step <= '0;
        acc  <= '0;
      end
      BK_MUL: begin
        prod <= opa * opb;
      end
      BK_ACC: begin
        if (!term) begin
          acc <= acc_sum;
        end else begin
          acc <= '0;
          if (wrap) begin
            wsat[col] <= ent_sat;
          end else begin
            t_mat[step[3:1]] <= ent_sat;
          end
        end
        step <= step + 4'd1;
      end
      BK_COPY: begin
        step <= '0;
        acc  <= '0;
      end
      BK_ADD: begin
        res_dx <= sat32(SATW'(wsat[0]) + SATW'(ox));
        res_dy <= sat32(SATW'(wsat[1]) + SATW'(oy));
      end
      BK_EMIT: begin
        if (emit_fire) begin
          out_ch.out_m11 <= r_mat[0];
          out_ch.out_m12 <= r_mat[1];
          out_ch.out_m21 <= r_mat[2];
          out_ch.out_m22 <= r_mat[3];
          out_ch.out_dx  <= res_dx;
          out_ch.out_dy  <= res_dy;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/affine_transform_list_composer.sv
`timescale 1ns / 1ps
// channel   dir  word                                         handshake
// in_ch     in   op_kind, param_a..param_f, pivot_x/y, last   valid/ready
// out_ch    out  out_m11, out_m12, out_m21, out_m22, dx, dy   valid/ready
//
// front end: translate, scale, matrix and unknown kinds go straight to the push state; rotate
//   first runs 3 steps of reciprocal angle reduction and 30 cordic steps; skews then
//   add the bit-serial tangent divide of 32+FRAC_BITS steps, none if the cosine is zero
// back end: each word is composed on its single 33x32 multiplier; the last word of a
//   list then runs the origin wrap and the emit step
// reset: synchronous, running matrix back to identity, queue and output empty
// stalls: a two-word queue parts front from back; a waiting result holds only the
//   back end at its emit step, the front end keeps accepting until the queue fills
module affine_transform_list_composer
  import afc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  afc_in_if.sink    in_ch,
  afc_out_if.source out_ch
);

  // front to queue
  logic     f_valid, f_ready;
  op_word_t f_word;
  // queue to back
  logic     b_valid, b_ready;
  op_word_t b_word;

  // classify the word and build its operation matrix
  afc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .word_valid (f_valid),
    .word_ready (f_ready),
    .word       (f_word)
  );

  afc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_word  (f_word),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_word  (b_word)
  );

  // compose onto the running matrix, wrap with the origin on the last word
  afc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (b_valid),
    .word_ready (b_ready),
    .word       (b_word),
    .out_ch     (out_ch)
  );

endmodule
